@@ src/alle_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package alle_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REVERSE  = 2'd1,
    ACT_TRAVERSE = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic               last_item;
  } out_word_t;

  typedef struct packed {
    logic       load_item;
    logic       start_rev;
    logic       start_trv;
    logic       do_insert;
    logic       rd;
    logic       rev_wr;
    logic       rev_done;
    logic       trv_adv;
    logic       emit_val;
    logic       emit_st;
    logic [1:0] resp_status;
  } cmd_t;

  typedef struct packed {
    logic cur_end;
    logic head_empty;
    logic full;
    logic trv_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ src/array_linked_list_engine_core.sv @@
// Channel | Signals                            | Word
// item    | item_valid, item_ready, item       | in_word_t  (action, item_value)
// result  | result_valid, result_ready, result | out_word_t (status, out_value, last_item)
//
// Insert: S_INSERT, then S_RESP; unused action or traverse of an empty list: S_RESP.
// Reverse: a read-then-write link step per list entry, then S_RESP.
// Traverse: one registered memory read per value.
// Reset is synchronous; no clearing pass is needed.
// A blocked result holds the engine; item_ready is high only while idle.
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_engine_core
  import alle_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_ready,
  input  wire in_word_t  item,
  output logic           result_valid,
  input  wire logic      result_ready,
  output out_word_t      result
);

  cmd_t  cmd;
  stat_t stat;

  alle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .action     (item.action),
    .stat       (stat),
    .cmd        (cmd)
  );

  alle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item_value   (item.item_value),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ src/alle_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module alle_ctrl
  import alle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire logic [1:0] action,
  input  wire stat_t      stat,
  output cmd_t            cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INSERT  = 7'b0000010,
    S_REV_RD  = 7'b0000100,
    S_REV_WR  = 7'b0001000,
    S_TRV_RD  = 7'b0010000,
    S_TRV_OUT = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] resp_status, resp_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      resp_status <= ST_OK;
    end else begin
      state       <= state_next;
      resp_status <= resp_status_next;
    end
  end

  always_comb begin
    state_next       = state;
    resp_status_next = resp_status;
    cmd              = '0;
    cmd.resp_status  = resp_status;
    item_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          case (action)
            ACT_INSERT: begin
              cmd.load_item = 1'b1;
              state_next    = S_INSERT;
            end
            ACT_REVERSE: begin
              cmd.start_rev = 1'b1;
              state_next    = S_REV_RD;
            end
            ACT_TRAVERSE: begin
              if (stat.head_empty) begin
                resp_status_next = ST_EMPTY;
                state_next       = S_RESP;
              end else begin
                cmd.start_trv = 1'b1;
                state_next    = S_TRV_RD;
              end
            end
            default: begin
              resp_status_next = ST_OK;
              state_next       = S_RESP;
            end
          endcase
        end
      end
      S_INSERT: begin
        if (stat.full) begin
          resp_status_next = ST_FULL;
        end else begin
          cmd.do_insert    = 1'b1;
          resp_status_next = ST_OK;
        end
        state_next = S_RESP;
      end
      S_REV_RD: begin
        if (stat.cur_end) begin
          cmd.rev_done     = 1'b1;
          resp_status_next = ST_OK;
          state_next       = S_RESP;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_REV_WR;
        end
      end
      S_REV_WR: begin
        cmd.rev_wr = 1'b1;
        state_next = S_REV_RD;
      end
      S_TRV_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_TRV_OUT;
      end
      S_TRV_OUT: begin
        if (stat.out_free) begin
          cmd.emit_val = 1'b1;
          if (stat.trv_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.trv_adv = 1'b1;
            state_next  = S_TRV_RD;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.emit_st = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // hold the traverse word while the output is blocked
  a_trv_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRV_OUT && !stat.out_free) |=> state == S_TRV_OUT)
    else $error("traverse left before emitting");

  a_rev_loop: assert property (@(posedge clk) disable iff (rst)
    cmd.rev_wr |=> state == S_REV_RD)
    else $error("reverse step did not return to read");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> state == S_IDLE)
    else $error("input taken outside idle");

endmodule

`default_nettype wire

@@ src/alle_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module alle_dp
  import alle_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] item_value,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output out_word_t               result
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [IW-1:0] END_IDX = IW'(DEPTH);

  logic signed [31:0] value_mem [DEPTH];
  logic [IW-1:0]      link_mem  [DEPTH];

  logic [IW-1:0]      head;
  logic [IW-1:0]      free;
  logic [IW-1:0]      cur;
  logic [IW-1:0]      prev;
  logic [IW-1:0]      steps;
  logic signed [31:0] item_reg;
  logic signed [31:0] value_q;
  logic [IW-1:0]      link_q;
  logic [IW-1:0]      plus_q;
  logic               fresh_q;
  logic [IW-1:0]      nxt;
  logic [AW-1:0]      cur_a;
  logic [AW-1:0]      free_a;

  assign cur_a  = cur[AW-1:0];
  assign free_a = free[AW-1:0];
  // entries at or above the fill point were never written; their link is taken as the next index
  assign nxt    = fresh_q ? plus_q : link_q;

  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      value_mem[free_a] <= item_reg;
    end
    if (cmd.rd) begin
      value_q <= value_mem[cur_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      link_mem[free_a] <= head;
    end else if (cmd.rev_wr) begin
      link_mem[cur_a] <= prev;
    end
    if (cmd.rd) begin
      link_q  <= link_mem[cur_a];
      plus_q  <= cur + 1'b1;
      fresh_q <= (cur >= free);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_reg <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= END_IDX;
      free  <= '0;
      cur   <= END_IDX;
      prev  <= END_IDX;
      steps <= '0;
    end else begin
      if (cmd.do_insert) begin
        head <= free;
        free <= free + 1'b1;
      end
      if (cmd.rev_done) begin
        head <= prev;
      end
      if (cmd.start_rev) begin
        cur   <= head;
        prev  <= END_IDX;
        steps <= '0;
      end
      if (cmd.start_trv) begin
        cur   <= head;
        steps <= '0;
      end
      if (cmd.rev_wr) begin
        prev  <= cur;
        cur   <= nxt;
        steps <= steps + 1'b1;
      end
      if (cmd.trv_adv) begin
        cur   <= nxt;
        steps <= steps + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_val || cmd.emit_st) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_val) begin
      result.status    <= ST_OK;
      result.out_value <= value_q;
      result.last_item <= stat.trv_last;
    end else if (cmd.emit_st) begin
      result.status    <= cmd.resp_status;
      result.out_value <= '0;
      result.last_item <= 1'b1;
    end
  end

  always_comb begin
    stat.cur_end    = (cur >= END_IDX) || (steps >= END_IDX);
    stat.head_empty = (head >= END_IDX);
    stat.full       = (free >= END_IDX);
    stat.trv_last   = (nxt >= END_IDX) || (steps >= END_IDX - 1'b1);
    stat.out_free   = !result_valid || result_ready;
  end

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |-> !stat.full)
    else $error("insert into full store");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_val || cmd.emit_st) |-> stat.out_free)
    else $error("output overwritten");

  a_ins_head: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |=> head == $past(free))
    else $error("head not moved to new slot");

  a_steps: assert property (@(posedge clk) disable iff (rst)
    steps <= END_IDX && free <= END_IDX)
    else $error("walk or fill count out of range");

endmodule

`default_nettype wire

@@ dv/array_linked_list_engine_core_tb.sv @@
`timescale 1ns / 1ps

module array_linked_list_engine_core_tb;
  import alle_pkg::*;

  localparam int DEPTH = 16;
  localparam int IXW = $clog2(DEPTH) + 1;
  localparam int AXW = $clog2(DEPTH);
  localparam int RAND_WORDS = 203;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 150;
  localparam int IDLE_LIMIT = 4000;
  localparam int DIR_ROWS = 27;

  localparam out_word_t OK_WORD = '{ST_OK, 32'sd0, 1'b1};

  typedef struct {
    action_t     act;
    logic [31:0] val;
    bit          typed;
    out_word_t   want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_word_t  item;
  logic      result_valid;
  logic      result_ready;
  out_word_t result;

  logic signed [31:0] list_vals [DEPTH];
  logic [IXW-1:0]     list_links [DEPTH];
  logic [IXW-1:0]     head_ix;
  logic [IXW-1:0]     free_ix;

  out_word_t want_q [$];
  int        mismatches = 0;
  int        words_sent = 0;
  int        words_checked = 0;
  int        full_rejects = 0;
  int        walks_sent = 0;
  int        idle_cycles = 0;
  int        item_left = 0;
  bit        item_flat = 1'b0;
  int        res_left = 0;
  bit        res_flat = 1'b0;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{ACT_TRAVERSE, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'sd0, 1'b1}},
    '{ACT_REVERSE,  32'h0000_0000, 1'b1, OK_WORD},
    '{ACT_NONE,     32'h5A5A_5A5A, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'h7FFF_FFFF, 1'b1, OK_WORD},
    '{ACT_TRAVERSE, 32'h0000_0000, 1'b1, '{ST_OK, 32'sh7FFF_FFFF, 1'b1}},
    '{ACT_REVERSE,  32'hFFFF_FFFF, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'h8000_0000, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'hFFFF_FFFF, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'h0000_0000, 1'b1, OK_WORD},
    '{ACT_TRAVERSE, 32'h0000_0000, 1'b0, OK_WORD},
    '{ACT_REVERSE,  32'h0000_0000, 1'b1, OK_WORD},
    '{ACT_TRAVERSE, 32'h0000_0000, 1'b0, OK_WORD},
    '{ACT_INSERT,   32'h0000_0001, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'h1234_5678, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'hDEAD_BEEF, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'h5555_5555, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'hAAAA_AAAA, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'h0F0F_0F0F, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'hF0F0_F0F0, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'h0000_FFFF, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'hFFFF_0000, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'h8000_0001, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'h7FFF_FFFE, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'hFFFF_FFFE, 1'b1, OK_WORD},
    '{ACT_INSERT,   32'hA5A5_A5A5, 1'b1, '{ST_FULL, 32'sd0, 1'b1}},
    '{ACT_REVERSE,  32'h0000_0000, 1'b1, OK_WORD},
    '{ACT_TRAVERSE, 32'h0000_0000, 1'b0, OK_WORD}
  };

  array_linked_list_engine_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  initial begin
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d idle cycles, %0d words pending", idle_cycles, want_q.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic int draw_gap(inout int left, inout bit flat);
    if (left == 0) begin
      left = $urandom_range(10, 40);
      flat = ($urandom_range(0, 2) == 0);
    end
    left--;
    return flat ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic list_apply(input in_word_t w, ref out_word_t res[$]);
    logic [IXW-1:0] slot;
    logic [IXW-1:0] prev;
    logic [IXW-1:0] cur;
    logic [IXW-1:0] nxt;
    int             n;
    res.delete();
    case (w.action)
      ACT_INSERT: begin
        if (free_ix >= DEPTH) begin
          res.push_back('{ST_FULL, 32'sd0, 1'b1});
        end else begin
          slot = free_ix;
          free_ix = list_links[slot[AXW-1:0]];
          list_vals[slot[AXW-1:0]] = w.item_value;
          list_links[slot[AXW-1:0]] = head_ix;
          head_ix = slot;
          res.push_back(OK_WORD);
        end
      end
      ACT_REVERSE: begin
        prev = IXW'(DEPTH);
        cur = head_ix;
        n = 0;
        while (cur < DEPTH && n < DEPTH) begin
          nxt = list_links[cur[AXW-1:0]];
          list_links[cur[AXW-1:0]] = prev;
          prev = cur;
          cur = nxt;
          n++;
        end
        head_ix = prev;
        res.push_back(OK_WORD);
      end
      ACT_TRAVERSE: begin
        if (head_ix >= DEPTH) begin
          res.push_back('{ST_EMPTY, 32'sd0, 1'b1});
        end else begin
          cur = head_ix;
          n = 0;
          while (cur < DEPTH && n < DEPTH) begin
            nxt = list_links[cur[AXW-1:0]];
            res.push_back('{ST_OK, list_vals[cur[AXW-1:0]],
                            (nxt >= DEPTH || n + 1 >= DEPTH)});
            n++;
            cur = nxt;
          end
        end
      end
      default: res.push_back(OK_WORD);
    endcase
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int        gap;
    out_word_t res [$];
    gap = draw_gap(item_left, item_flat);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    list_apply(w, res);
    if (typed) begin
      want_q.push_back(want);
    end else begin
      foreach (res[k]) want_q.push_back(res[k]);
    end
    words_sent++;
    if (w.action == ACT_TRAVERSE) walks_sent++;
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (want_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected result word: status %0d value %0d last %0b",
                 got.status, got.out_value, got.last_item);
      end
    end else begin
      want = want_q.pop_front();
      if (got.status != want.status || got.out_value != want.out_value ||
          got.last_item != want.last_item) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result word %0d: expected status %0d value %0d last %0b, got %0d %0d %0b",
                   words_checked, want.status, want.out_value, want.last_item,
                   got.status, got.out_value, got.last_item);
        end
      end
    end
    if (got.status == ST_FULL) full_rejects++;
    words_checked++;
  endtask

  initial begin
    int  gap;
    bit  hold_done;
    hold_done = 1'b0;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(res_left, res_flat);
      if (!hold_done && words_checked >= HOLD_AT) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      check_word(result);
    end
  end

  initial begin
    in_word_t w;
    int       pick;
    item_valid <= 1'b0;
    item <= '0;
    for (int i = 0; i < DEPTH; i++) begin
      list_vals[i] = '0;
      list_links[i] = IXW'(i + 1);
    end
    head_ix = IXW'(DEPTH);
    free_ix = '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (dir_tbl[i]) begin
      w.action = dir_tbl[i].act;
      w.item_value = dir_tbl[i].val;
      send_word(w, dir_tbl[i].typed, dir_tbl[i].want);
    end

    for (int i = 0; i < RAND_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        w.action = ACT_TRAVERSE;
      end else if (pick < 70) begin
        w.action = ACT_REVERSE;
      end else if (pick < 90) begin
        w.action = ACT_INSERT;
      end else begin
        w.action = ACT_NONE;
      end
      w.item_value = $urandom;
      send_word(w, 1'b0, OK_WORD);
    end
    item_valid <= 1'b0;

    while (want_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Sent %0d words (%0d traversals), checked %0d result words",
             words_sent, walks_sent, words_checked);
    $display("Saw %0d inserts rejected on a full list", full_rejects);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
